FILE: rtl/erfc_pkg.sv
// ----------------------------------------------------------------------------
// erfc_pkg
// shared constants, coefficient tables and pipeline payload types for the
// complementary error function datapath
// ----------------------------------------------------------------------------
package erfc_pkg;

    // parameter defaults
    localparam int IN_FRAC_DEF  = 12;
    localparam int OUT_FRAC_DEF = 16;
    localparam int OUT_FRAC_MAX = 24;

    // internal fixed point
    localparam int QB      = 28;
    localparam int Y_W     = 31;  // |x| in Q28, below 6.0
    localparam int P_W     = 33;  // polynomial value, signed
    localparam int PS_W    = 37;  // polynomial sum before narrowing, signed
    localparam int A_W     = 36;  // exponent argument
    localparam int S_W     = 9;   // exponent shift
    localparam int R_W     = 28;  // reduced argument
    localparam int TERM_W  = 29;  // series term
    localparam int SUM_W   = 31;  // series sum
    localparam int E_W     = 30;  // exp result
    localparam int SQ_W    = 32;  // sqrt(pi) * y
    localparam int H_W     = 33;
    localparam int D_W     = 34;
    localparam int N_W     = 56;
    localparam int QD_W    = OUT_FRAC_MAX + 2;
    localparam int EXP_TERMS = 14;

    localparam logic [TERM_W-1:0] Q_ONE    = TERM_W'(1) << QB;
    localparam logic [R_W-1:0]    LN2_Q    = 28'd186065280;
    localparam logic [28:0]       SQRTPI_Q = 29'd475789458;
    localparam logic [24:0]       LN2_RECIP = 25'((64'd1 << 52) / 64'd186065280);

    // polynomial, Q28: leading coefficient, then horner steps, last step adds zero
    localparam logic signed [PS_W-1:0] POLY_C4 = -37'sd38759;
    localparam logic signed [PS_W-1:0] HORNER_C [5] = '{
        37'sd437694, -37'sd96497, -37'sd21324770, 37'sd173549271, 37'sd0
    };

    typedef struct packed {
        logic op;
        logic sat;
        logic neg;
        logic pos;
    } tag_t;

    typedef struct packed {
        tag_t            tag;
        logic [Y_W-1:0]  y;
        logic [SQ_W-1:0] sq;
        logic [A_W-1:0]  yy;
    } hpay_t;

    typedef struct packed {
        logic [S_W-1:0]    s;
        logic [R_W-1:0]    r;
        logic [TERM_W-1:0] term;
        logic [SUM_W-1:0]  sum;
    } lane_t;

    typedef struct packed {
        tag_t            tag;
        logic [SQ_W-1:0] sq;
        lane_t [1:0]     lane;
    } tpay_t;

    typedef struct packed {
        tag_t            tag;
        logic            ovf;
        logic [D_W-1:0]  d;
        logic [N_W-1:0]  rem;
        logic [QD_W-1:0] q;
    } dpay_t;

endpackage

FILE: rtl/erfc_in_if.sv
// ----------------------------------------------------------------------------
// erfc_in_if
// argument channel: signed x and operation select
// ----------------------------------------------------------------------------
interface erfc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x;
    logic               operation;

    modport source (output valid, output x, output operation, input ready);
    modport sink   (input valid, input x, input operation, output ready);
endinterface

FILE: rtl/erfc_out_if.sv
// ----------------------------------------------------------------------------
// erfc_out_if
// result channel: unsigned value and saturation flag
// ----------------------------------------------------------------------------
interface erfc_out_if
    import erfc_pkg::*;
#(
    parameter int VALUE_W = OUT_FRAC_DEF + 1
);
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               saturated;

    modport source (output valid, output value, output saturated, input ready);
    modport sink   (input valid, input value, input saturated, output ready);
endinterface

FILE: rtl/complementary_error_function.sv
// throughput: one item per cycle, set by the single-item-per-stage pipeline
// the pipeline halts only while the two-entry output buffer is full
// reset clears all stage valid bits and the output buffer pointers, no clearing pass
// ----------------------------------------------------------------------------
// complementary_error_function
// pipelined erfc/2 evaluation: polynomial, two exp lanes over a row of taylor
// term cells, then a row of restoring division cells
// ----------------------------------------------------------------------------
module complementary_error_function
    import erfc_pkg::*;
#(
    parameter int INPUT_FRAC_BITS  = IN_FRAC_DEF,
    parameter int OUTPUT_FRAC_BITS = OUT_FRAC_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    erfc_in_if.sink   arg,
    erfc_out_if.source res
);

    localparam int VAL_W   = OUTPUT_FRAC_BITS + 1;
    localparam int QW      = OUTPUT_FRAC_BITS + 2;
    localparam int Y_SHIFT = QB - INPUT_FRAC_BITS;
    localparam logic [VAL_W-1:0] OUT_ONE  = VAL_W'(1) << OUTPUT_FRAC_BITS;
    localparam logic [31:0]      LIMIT_IN = 32'(6) << INPUT_FRAC_BITS;

    // global advance: the whole row moves unless the output buffer is full
    logic en;
    logic [1:0] cnt_reg, cnt_next;

    assign en        = (cnt_reg != 2'd2);
    assign arg.ready = en;

    // ---------------- input register ----------------
    logic              v0_reg;
    logic [15:0]       x0_reg;
    logic              op0_reg;

    // ---------------- decode: sign, magnitude, range ----------------
    logic              v1_reg;
    tag_t              tag1_reg, tag1_next;
    logic [Y_W-1:0]    y1_reg, y1_next;
    logic [16:0]       mag1;
    logic [47:0]       yfull;

    always_comb
    begin
        tag1_next.op  = op0_reg;
        tag1_next.neg = x0_reg[15];
        tag1_next.pos = !x0_reg[15] && (x0_reg != 16'd0);
        mag1          = x0_reg[15] ? 17'h10000 - {1'b0, x0_reg} : {1'b0, x0_reg};
        tag1_next.sat = (32'(mag1) >= LIMIT_IN);
        yfull         = 48'(mag1) << Y_SHIFT;
        // limit items never use y, keep it in range
        y1_next       = tag1_next.sat ? '0 : yfull[Y_W-1:0];
    end

    // ---------------- products for sqrt(pi)*y and y*y ----------------
    logic              v2_reg;
    tag_t              tag2_reg;
    logic [Y_W-1:0]    y2_reg;
    logic [59:0]       sqp2_reg;
    logic [61:0]       yyp2_reg;

    // ---------------- rounding into Q28 ----------------
    logic              v3_reg;
    hpay_t             hp3_reg, hp3_next;
    logic [60:0]       sq_rnd;
    logic [62:0]       yy_rnd;

    always_comb
    begin
        sq_rnd        = 61'(sqp2_reg) + (61'd1 << (QB - 1));
        yy_rnd        = 63'(yyp2_reg) + (63'd1 << (QB - 1));
        hp3_next.tag  = tag2_reg;
        hp3_next.y    = y2_reg;
        hp3_next.sq   = sq_rnd[QB +: SQ_W];
        hp3_next.yy   = A_W'(yy_rnd[62:QB]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= arg.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg   <= arg.x;
            op0_reg  <= arg.operation;
            tag1_reg <= tag1_next;
            y1_reg   <= y1_next;
            tag2_reg <= tag1_reg;
            y2_reg   <= y1_reg;
            sqp2_reg <= 60'(SQRTPI_Q) * 60'(y1_reg);
            yyp2_reg <= 62'(y1_reg) * 62'(y1_reg);
            hp3_reg  <= hp3_next;
        end
    end

    // ---------------- horner chain, last step forms z = p*y ----------------
    logic                   hv [0:5];
    hpay_t                  hp [0:5];
    logic signed [PS_W-1:0] pp [0:5];

    assign hv[0] = v3_reg;
    assign hp[0] = hp3_reg;
    assign pp[0] = POLY_C4;

    for (genvar j = 0; j < 5; j++)
    begin : g_horner
        logic                   va_reg, vb_reg;
        hpay_t                  pa_reg, pb_reg;
        logic [63:0]            prod_reg, prod_next;
        logic                   sign_reg;
        logic signed [PS_W-1:0] psum_reg, psum_next;
        logic [P_W-1:0]         pmag;
        logic [P_W-1:0]         pnarrow;
        logic [63:0]            rnd;
        logic [35:0]            m;
        logic signed [PS_W-1:0] ms;

        always_comb
        begin
            pnarrow   = pp[j][P_W-1:0];
            pmag      = pnarrow[P_W-1] ? P_W'(-pnarrow) : pnarrow;
            prod_next = 64'(pmag) * 64'(hp[j].y);
            // magnitude rounded half away from zero
            rnd       = prod_reg + (64'd1 << (QB - 1));
            m         = rnd[QB +: 36];
            ms        = sign_reg ? -$signed({1'b0, m}) : $signed({1'b0, m});
            psum_next = HORNER_C[j] + ms;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
            end
            else if (en)
            begin
                va_reg <= hv[j];
                vb_reg <= va_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg <= prod_next;
                sign_reg <= pnarrow[P_W-1];
                pa_reg   <= hp[j];
                psum_reg <= psum_next;
                pb_reg   <= pa_reg;
            end
        end

        assign hv[j+1] = vb_reg;
        assign hp[j+1] = pb_reg;
        assign pp[j+1] = psum_reg;
    end

    // ---------------- range reduction a = k*ln2 + rem, lane 0 z, lane 1 y*y ----------------
    logic [A_W-1:0]  ea [2];
    logic [63:0]     est_prod [2];
    logic [8:0]      est_next [2];

    assign ea[0] = pp[5][PS_W-1] ? '0 : pp[5][A_W-1:0];
    assign ea[1] = hp[5].yy;

    logic            e1_v_reg, e2_v_reg, e3_v_reg;
    tag_t            e1_tag_reg, e2_tag_reg;
    logic [SQ_W-1:0] e1_sq_reg, e2_sq_reg;
    logic [A_W-1:0]  e1_a_reg [2];
    logic [8:0]      e1_est_reg [2];
    logic [8:0]      e2_est_reg [2];
    logic [28:0]     e2_rem_reg [2];
    logic [28:0]     rem0_next [2];
    logic [37:0]     rem0_full [2];
    tpay_t           e3_pay_reg, e3_pay_next;
    logic            ge3 [2];
    logic [28:0]     rem3 [2];

    always_comb
    begin
        e3_pay_next.tag = e2_tag_reg;
        e3_pay_next.sq  = e2_sq_reg;
        for (int l = 0; l < 2; l++)
        begin
            // estimate from the top bits, low by at most one
            est_prod[l]  = 64'(ea[l][A_W-1:20]) * 64'(LN2_RECIP);
            est_next[l]  = est_prod[l][32 +: 9];
            rem0_full[l] = 38'(e1_a_reg[l]) - 38'(e1_est_reg[l]) * 38'(LN2_Q);
            rem0_next[l] = rem0_full[l][28:0];
            ge3[l]       = e2_rem_reg[l] >= 29'(LN2_Q);
            rem3[l]      = ge3[l] ? e2_rem_reg[l] - 29'(LN2_Q) : e2_rem_reg[l];
            e3_pay_next.lane[l].s    = e2_est_reg[l] + S_W'(ge3[l]) + 9'd1;
            e3_pay_next.lane[l].r    = LN2_Q - rem3[l][R_W-1:0];
            e3_pay_next.lane[l].term = Q_ONE;
            e3_pay_next.lane[l].sum  = SUM_W'(Q_ONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
            e3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_v_reg <= hv[5];
            e2_v_reg <= e1_v_reg;
            e3_v_reg <= e2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_tag_reg <= hp[5].tag;
            e1_sq_reg  <= hp[5].sq;
            e2_tag_reg <= e1_tag_reg;
            e2_sq_reg  <= e1_sq_reg;
            e3_pay_reg <= e3_pay_next;
            for (int l = 0; l < 2; l++)
            begin
                e1_a_reg[l]   <= ea[l];
                e1_est_reg[l] <= est_next[l];
                e2_est_reg[l] <= e1_est_reg[l];
                e2_rem_reg[l] <= rem0_next[l];
            end
        end
    end

    // ---------------- taylor series of exp(r), one cell per later term ----------------
    logic  tv [0:EXP_TERMS-1];
    tpay_t tp [0:EXP_TERMS-1];

    assign tv[0] = e3_v_reg;
    assign tp[0] = e3_pay_reg;

    for (genvar n = 1; n < EXP_TERMS; n++)
    begin : g_term
        erfc_term_cell #(
            .N (n)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (tv[n-1]),
            .in_pay    (tp[n-1]),
            .out_valid (tv[n]),
            .out_pay   (tp[n])
        );
    end

    // ---------------- scale by 2^-(k+1), round half up ----------------
    logic            f_v_reg;
    tag_t            f_tag_reg;
    logic [SQ_W-1:0] f_sq_reg;
    logic [E_W-1:0]  f_e_reg [2];
    logic [E_W-1:0]  f_e_next [2];
    logic [63:0]     f_shift [2];
    lane_t           fl [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            fl[l]      = tp[EXP_TERMS-1].lane[l];
            f_shift[l] = (64'(fl[l].sum) + (64'd1 << (fl[l].s - 9'd1))) >> fl[l].s;
            f_e_next[l] = (fl[l].s >= 9'd62) ? '0 : f_shift[l][E_W-1:0];
        end
    end

    // ---------------- h, divisor, numerator, overflow check ----------------
    logic            g_v_reg;
    dpay_t           g_pay_reg, g_pay_next;
    logic [H_W-1:0]  h_sum, h_val;
    logic [N_W-1:0]  numer;

    always_comb
    begin
        h_sum = H_W'(f_sq_reg) + H_W'(f_e_reg[0]);
        h_val = (h_sum == '0) ? H_W'(1) : h_sum;
        numer = (N_W'(f_e_reg[1]) << OUTPUT_FRAC_BITS) + N_W'(h_val);
        g_pay_next.tag = f_tag_reg;
        g_pay_next.d   = {h_val, 1'b0};
        g_pay_next.rem = numer;
        g_pay_next.q   = '0;
        // quotient too wide for the division row: clamps to one anyway
        g_pay_next.ovf = 64'(numer) >= (64'({h_val, 1'b0}) << QW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= tv[EXP_TERMS-1];
            g_v_reg <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_tag_reg  <= tp[EXP_TERMS-1].tag;
            f_sq_reg   <= tp[EXP_TERMS-1].sq;
            f_e_reg[0] <= f_e_next[0];
            f_e_reg[1] <= f_e_next[1];
            g_pay_reg  <= g_pay_next;
        end
    end

    // ---------------- restoring division, msb first ----------------
    logic  dv [0:QW];
    dpay_t dp [0:QW];

    assign dv[0] = g_v_reg;
    assign dp[0] = g_pay_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        erfc_div_cell #(
            .BIT (QW - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv[i]),
            .in_pay    (dp[i]),
            .out_valid (dv[i+1]),
            .out_pay   (dp[i+1])
        );
    end

    // ---------------- final select ----------------
    logic [QW-1:0]    quo;
    logic [VAL_W-1:0] t_val, comp, fin_val;
    dpay_t            last;

    always_comb
    begin
        last  = dp[QW];
        quo   = last.q[QW-1:0];
        t_val = (last.ovf || (quo > QW'(OUT_ONE))) ? OUT_ONE : quo[VAL_W-1:0];
        if (last.tag.sat)
        begin
            comp = last.tag.neg ? OUT_ONE : '0;
        end
        else
        begin
            comp = last.tag.pos ? t_val : OUT_ONE - t_val;
        end
        fin_val = last.tag.op ? OUT_ONE - comp : comp;
    end

    // ---------------- two-entry output buffer ----------------
    logic [VAL_W-1:0] ob_val_reg [2];
    logic             ob_sat_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic             push, pop;

    assign push = en && dv[QW];
    assign pop  = res.valid && res.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ob_val_reg[wr_ptr_reg] <= fin_val;
            ob_sat_reg[wr_ptr_reg] <= last.tag.sat;
        end
    end

    assign res.valid     = (cnt_reg != 2'd0);
    assign res.value     = ob_val_reg[rd_ptr_reg];
    assign res.saturated = ob_sat_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    // buffer occupancy stays within its two entries
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    // an input transfer lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (arg.valid && arg.ready) |=> v0_reg)
        else $error("accepted item lost at input register");

    // a limit result is exactly zero or one
    a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.saturated) |-> (res.value == '0 || res.value == OUT_ONE))
        else $error("saturated result is not a limit value");

    // result never exceeds one
    a_value_max: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.value <= OUT_ONE))
        else $error("result above one");

    // a stalled row holds its last stage
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && dv[QW]) |=> dv[QW])
        else $error("pipeline item dropped during stall");
`endif

endmodule

FILE: rtl/erfc_term_cell.sv
// ----------------------------------------------------------------------------
// erfc_term_cell
// one taylor term for both exp lanes: term = ((term * r) >> 28) / N, sum += term
// ----------------------------------------------------------------------------
module erfc_term_cell
    import erfc_pkg::*;
#(
    parameter int N = 1
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  tpay_t in_pay,
    output logic  out_valid,
    output tpay_t out_pay
);

    localparam logic [31:0] RECIP = 32'(((64'd1 << 32) - 64'd1) / 64'(N));
    localparam logic [3:0]  DIV   = 4'(N);
    localparam int PROD_W = TERM_W + R_W;

    logic                v1_reg, v2_reg, v3_reg;
    tpay_t               pay1_reg, pay2_reg, pay3_reg;
    logic [PROD_W-1:0]   prod1_reg [2];
    logic [TERM_W-1:0]   val2_reg  [2];
    logic [TERM_W-1:0]   quo2_reg  [2];
    logic [PROD_W-1:0]   prod1_next [2];
    logic [TERM_W-1:0]   val2_next  [2];
    logic [TERM_W-1:0]   quo2_next  [2];
    logic [63:0]         recip_prod [2];
    logic [32:0]         rem3 [2];
    logic [TERM_W-1:0]   term3 [2];
    tpay_t               pay3_next;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            prod1_next[l] = PROD_W'(in_pay.lane[l].term) * PROD_W'(in_pay.lane[l].r);
            val2_next[l]  = prod1_reg[l][QB +: TERM_W];
            recip_prod[l] = 64'(val2_next[l]) * 64'(RECIP);
            quo2_next[l]  = recip_prod[l][32 +: TERM_W];
        end
    end

    // reciprocal estimate is low by at most one
    always_comb
    begin
        pay3_next = pay2_reg;
        for (int l = 0; l < 2; l++)
        begin
            rem3[l]  = 33'(val2_reg[l]) - 33'(quo2_reg[l]) * 33'(DIV);
            term3[l] = (rem3[l] >= 33'(DIV)) ? quo2_reg[l] + 1'b1 : quo2_reg[l];
            pay3_next.lane[l].term = term3[l];
            pay3_next.lane[l].sum  = pay2_reg.lane[l].sum + SUM_W'(term3[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay1_reg <= in_pay;
            pay2_reg <= pay1_reg;
            pay3_reg <= pay3_next;
            for (int l = 0; l < 2; l++)
            begin
                prod1_reg[l] <= prod1_next[l];
                val2_reg[l]  <= val2_next[l];
                quo2_reg[l]  <= quo2_next[l];
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_pay   = pay3_reg;

endmodule

FILE: rtl/erfc_div_cell.sv
// ----------------------------------------------------------------------------
// erfc_div_cell
// one restoring division step, quotient bit BIT
// ----------------------------------------------------------------------------
module erfc_div_cell
    import erfc_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  dpay_t in_pay,
    output logic  out_valid,
    output dpay_t out_pay
);

    logic        v_reg;
    dpay_t       pay_reg;
    dpay_t       pay_next;
    logic [63:0] dsh;
    logic [63:0] diff;
    logic        ge;

    always_comb
    begin
        dsh      = 64'(in_pay.d) << BIT;
        diff     = 64'(in_pay.rem) - dsh;
        ge       = 64'(in_pay.rem) >= dsh;
        pay_next = in_pay;
        pay_next.q[BIT] = ge;
        if (ge)
        begin
            pay_next.rem = N_W'(diff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg <= pay_next;
        end
    end

    assign out_valid = v_reg;
    assign out_pay   = pay_reg;

endmodule
